/* src/pccf_pkg.sv */
`default_nettype none

package pccf_pkg;

    // Field widths
    localparam int CoordW  = 20;
    localparam int RangeW  = 19;
    localparam int CosW    = 16;
    localparam int ByteW   = 8;
    localparam int TimeW   = 32;
    localparam int CountW  = 20;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 20;

    // Derived arithmetic widths
    localparam int SqW     = 2 * CoordW - 1;     // x*x, max 2^38
    localparam int SumW    = 2 * CoordW;         // x*x + y*y (+ z*z)
    localparam int RSqW    = 2 * RangeW;         // range limit squared
    localparam int CSqW    = 2 * CosW - 1;       // cos squared, max 2^30
    localparam int HalfW   = SumW / 2;           // partial product split
    localparam int PpW     = CSqW + HalfW;
    localparam int CosFrac = 2 * (CosW - 1);     // Q1.15 squared -> 2^30
    localparam int CmpW    = CSqW + SumW;

    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 136;

    localparam int MaxFramePointsDefault = 1048575;
    localparam int CountFieldMax         = 1048575;

    // Register indexes
    localparam logic [CfgAddrW-1:0] CFG_GROUND_FLOOR = 3'd0;
    localparam logic [CfgAddrW-1:0] CFG_Z_CEILING    = 3'd1;
    localparam logic [CfgAddrW-1:0] CFG_X_FLOOR      = 3'd2;
    localparam logic [CfgAddrW-1:0] CFG_RANGE_MIN    = 3'd3;
    localparam logic [CfgAddrW-1:0] CFG_RANGE_MAX    = 3'd4;
    localparam logic [CfgAddrW-1:0] CFG_HALF_FOV_COS = 3'd5;
    localparam logic [CfgAddrW-1:0] CFG_Y_LIMIT      = 3'd6;
    localparam logic [CfgAddrW-1:0] CFG_USE_3D       = 3'd7;

    // Reset values
    localparam logic signed [CoordW-1:0] GROUND_FLOOR_RST = -20'sd524288;
    localparam logic signed [CoordW-1:0] Z_CEILING_RST    = 20'sd3000;
    localparam logic signed [CoordW-1:0] X_FLOOR_RST      = 20'sd0;
    localparam logic [RangeW-1:0]        RANGE_MIN_RST    = 19'd1000;
    localparam logic [RangeW-1:0]        RANGE_MAX_RST    = 19'd8000;
    localparam logic signed [CosW-1:0]   HALF_FOV_COS_RST = 16'sd23170;
    localparam logic [RangeW-1:0]        Y_LIMIT_RST      = 19'd0;
    localparam logic [RSqW-1:0]          RANGE_MIN_SQ_RST = 38'd1000000;
    localparam logic [RSqW-1:0]          RANGE_MAX_SQ_RST = 38'd64000000;
    localparam logic [CSqW-1:0]          COS_SQ_RST       = 31'd536848900;

    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
        logic [ByteW-1:0]         reflectivity;
        logic [ByteW-1:0]         tag;
        logic [ByteW-1:0]         line;
        logic [TimeW-1:0]         offset_time;
        logic                     last;
    } point_t;

endpackage

`default_nettype wire

/* src/point_cloud_crop_filter.sv */
`default_nettype none

// Point cloud crop filter.
// Input: one lidar point per s_ transaction. s_tdata carries x, y, z (signed mm),
// reflectivity, tag, line and offset_time; s_tuser flags finite coordinates;
// s_tlast marks the last point of a frame.
// Output: one m_ transaction per kept point, and one for every frame-closing
// point whether kept or not. m_tuser = point present (has_point), m_tlast = frame
// end; on a frame end the count field holds the saturating number of points kept
// in the frame. Dropped points that do not close a frame produce nothing.
// Throughput: one point per cycle while the output is not stalled by m_tready.
// Pipeline registers, in order: squares + local compares, range sum and compare,
// sector partial products, sector compare + count, output register.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata; user writes only while pipe is empty,
// unenforced by the block; range-limit and sector-cosine squares are formed at write.
// Reset (aresetn low, synchronous): pipe empties, kept count clears, registers
// return to their defaults.
// Stall: when m_tready is low the output register holds and the pipe fills up
// behind it; s_tready drops only once every stage holds a point.
module point_cloud_crop_filter #(
    parameter int MAX_FRAME_POINTS = pccf_pkg::MaxFramePointsDefault
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [pccf_pkg::CfgAddrW-1:0] cfg_addr,
    input  wire logic [pccf_pkg::CfgDataW-1:0] cfg_wdata,
    // point input
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // x[19:0] y[39:20] z[59:40] reflectivity[67:60] tag[75:68] line[83:76]
    // offset_time[115:84], zero pad [119:116]
    input  wire logic [pccf_pkg::S_DATA_W-1:0] s_tdata,
    // coords_finite[0]
    input  wire logic                          s_tuser,
    input  wire logic                          s_tlast,
    // result output
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // out_x[19:0] out_y[39:20] out_z[59:40] out_reflectivity[67:60]
    // out_tag[75:68] out_line[83:76] out_offset_time[115:84]
    // frame_kept_count[135:116]
    output logic [pccf_pkg::M_DATA_W-1:0]      m_tdata,
    // has_point[0]
    output logic                               m_tuser,
    output logic                               m_tlast
);

    localparam int CW   = pccf_pkg::CountW;
    localparam int CapI = (MAX_FRAME_POINTS < pccf_pkg::CountFieldMax) ?
                          MAX_FRAME_POINTS : pccf_pkg::CountFieldMax;
    localparam logic [CW-1:0] KEEP_CAP = CW'(CapI);

    // ---------------- configuration registers ----------------
    logic signed [pccf_pkg::CoordW-1:0] ground_floor_reg;
    logic signed [pccf_pkg::CoordW-1:0] z_ceiling_reg;
    logic signed [pccf_pkg::CoordW-1:0] x_floor_reg;
    logic signed [pccf_pkg::CosW-1:0]   half_fov_cos_reg;
    logic [pccf_pkg::RangeW-1:0]        y_limit_reg;
    logic                               use_3d_reg;
    logic [pccf_pkg::RSqW-1:0]          rmin_sq_reg;
    logic [pccf_pkg::RSqW-1:0]          rmax_sq_reg;
    logic [pccf_pkg::CSqW-1:0]          cos_sq_reg;

    logic [pccf_pkg::RSqW-1:0]          wr_range_sq;
    logic signed [2*pccf_pkg::CosW-1:0] wr_cos_sq;

    assign wr_range_sq = cfg_wdata[pccf_pkg::RangeW-1:0] * cfg_wdata[pccf_pkg::RangeW-1:0];
    assign wr_cos_sq   = $signed(cfg_wdata[pccf_pkg::CosW-1:0]) *
                         $signed(cfg_wdata[pccf_pkg::CosW-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ground_floor_reg <= pccf_pkg::GROUND_FLOOR_RST;
            z_ceiling_reg    <= pccf_pkg::Z_CEILING_RST;
            x_floor_reg      <= pccf_pkg::X_FLOOR_RST;
            half_fov_cos_reg <= pccf_pkg::HALF_FOV_COS_RST;
            y_limit_reg      <= pccf_pkg::Y_LIMIT_RST;
            use_3d_reg       <= 1'b0;
            rmin_sq_reg      <= pccf_pkg::RANGE_MIN_SQ_RST;
            rmax_sq_reg      <= pccf_pkg::RANGE_MAX_SQ_RST;
            cos_sq_reg       <= pccf_pkg::COS_SQ_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                pccf_pkg::CFG_GROUND_FLOOR: ground_floor_reg <= $signed(cfg_wdata);
                pccf_pkg::CFG_Z_CEILING:    z_ceiling_reg    <= $signed(cfg_wdata);
                pccf_pkg::CFG_X_FLOOR:      x_floor_reg      <= $signed(cfg_wdata);
                pccf_pkg::CFG_RANGE_MIN:    rmin_sq_reg      <= wr_range_sq;
                pccf_pkg::CFG_RANGE_MAX:    rmax_sq_reg      <= wr_range_sq;
                pccf_pkg::CFG_HALF_FOV_COS: begin
                    half_fov_cos_reg <= $signed(cfg_wdata[pccf_pkg::CosW-1:0]);
                    cos_sq_reg       <= wr_cos_sq[pccf_pkg::CSqW-1:0];
                end
                pccf_pkg::CFG_Y_LIMIT:      y_limit_reg <= cfg_wdata[pccf_pkg::RangeW-1:0];
                pccf_pkg::CFG_USE_3D:       use_3d_reg  <= cfg_wdata[0];
            endcase
        end
    end

    // ---------------- handshake chain ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_out;

    assign rdy_out  = !m_valid_reg || m_tready;
    assign rdy4     = !v4_reg || rdy_out;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: squares and plain limit tests ----------------
    pccf_pkg::point_t            in_pt;
    logic signed [2*pccf_pkg::CoordW-1:0] x_sq_full, y_sq_full, z_sq_full;
    logic [pccf_pkg::CoordW-1:0] abs_y;
    logic                        y_ok, pre_ok;

    assign in_pt.x            = $signed(s_tdata[19:0]);
    assign in_pt.y            = $signed(s_tdata[39:20]);
    assign in_pt.z            = $signed(s_tdata[59:40]);
    assign in_pt.reflectivity = s_tdata[67:60];
    assign in_pt.tag          = s_tdata[75:68];
    assign in_pt.line         = s_tdata[83:76];
    assign in_pt.offset_time  = s_tdata[115:84];
    assign in_pt.last         = s_tlast;

    assign x_sq_full = in_pt.x * in_pt.x;
    assign y_sq_full = in_pt.y * in_pt.y;
    assign z_sq_full = in_pt.z * in_pt.z;

    assign abs_y  = in_pt.y[pccf_pkg::CoordW-1] ? (~in_pt.y + 1'b1) : in_pt.y;
    assign y_ok   = (y_limit_reg == '0) || (abs_y <= {1'b0, y_limit_reg});
    assign pre_ok = s_tuser && (in_pt.z >= ground_floor_reg) &&
                    (in_pt.z <= z_ceiling_reg) && (in_pt.x >= x_floor_reg) && y_ok;

    pccf_pkg::point_t           s1_pt_reg;
    logic [pccf_pkg::SqW-1:0]   s1_x_sq_reg, s1_y_sq_reg, s1_z_sq_reg;
    logic                       s1_ok_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_pt_reg   <= in_pt;
            s1_x_sq_reg <= x_sq_full[pccf_pkg::SqW-1:0];
            s1_y_sq_reg <= y_sq_full[pccf_pkg::SqW-1:0];
            s1_z_sq_reg <= z_sq_full[pccf_pkg::SqW-1:0];
            s1_ok_reg   <= pre_ok;
        end
    end

    // ---------------- stage 2: range sum and range window ----------------
    logic [pccf_pkg::SumW-1:0] planar, r_sq;
    logic                      range_ok;

    assign planar   = pccf_pkg::SumW'(s1_x_sq_reg) + pccf_pkg::SumW'(s1_y_sq_reg);
    assign r_sq     = planar + (use_3d_reg ? pccf_pkg::SumW'(s1_z_sq_reg) : '0);
    // effective max is max(min, max): above it means above both
    assign range_ok = (r_sq >= pccf_pkg::SumW'(rmin_sq_reg)) &&
                      ((r_sq <= pccf_pkg::SumW'(rmax_sq_reg)) ||
                       (r_sq <= pccf_pkg::SumW'(rmin_sq_reg)));

    pccf_pkg::point_t          s2_pt_reg;
    logic [pccf_pkg::SumW-1:0] s2_planar_reg;
    logic [pccf_pkg::SqW-1:0]  s2_x_sq_reg;
    logic                      s2_ok_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            s2_pt_reg     <= s1_pt_reg;
            s2_planar_reg <= planar;
            s2_x_sq_reg   <= s1_x_sq_reg;
            s2_ok_reg     <= s1_ok_reg && range_ok;
        end
    end

    // ---------------- stage 3: cos^2 * planar in two halves ----------------
    pccf_pkg::point_t         s3_pt_reg;
    logic [pccf_pkg::PpW-1:0] s3_pp_lo_reg, s3_pp_hi_reg;
    logic [pccf_pkg::SqW-1:0] s3_x_sq_reg;
    logic                     s3_ok_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            s3_pt_reg    <= s2_pt_reg;
            s3_pp_lo_reg <= cos_sq_reg * s2_planar_reg[pccf_pkg::HalfW-1:0];
            s3_pp_hi_reg <= cos_sq_reg * s2_planar_reg[pccf_pkg::SumW-1:pccf_pkg::HalfW];
            s3_x_sq_reg  <= s2_x_sq_reg;
            s3_ok_reg    <= s2_ok_reg;
        end
    end

    // ---------------- stage 4: sector compare, frame count ----------------
    logic [pccf_pkg::CmpW-1:0] sec_rhs, sec_lhs;
    logic                      cos_pos, sector_ok;

    assign sec_rhs = {s3_pp_hi_reg, {pccf_pkg::HalfW{1'b0}}} +
                     pccf_pkg::CmpW'(s3_pp_lo_reg);
    assign sec_lhs = pccf_pkg::CmpW'({s3_x_sq_reg, {pccf_pkg::CosFrac{1'b0}}});
    assign cos_pos = !half_fov_cos_reg[pccf_pkg::CosW-1] && (half_fov_cos_reg != '0);

    // forward half: cos <= 0 always passes; rear half: needs cos <= 0
    assign sector_ok = !s3_pt_reg.x[pccf_pkg::CoordW-1] ?
                       (!cos_pos || (sec_lhs >= sec_rhs)) :
                       (!cos_pos && (sec_lhs <= sec_rhs));

    pccf_pkg::point_t         s4_pt_reg;
    logic                     s4_keep_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            s4_pt_reg   <= s3_pt_reg;
            s4_keep_reg <= s3_ok_reg && sector_ok;
        end
    end

    logic [CW-1:0] kept_reg, kept_next, kept_inc;

    assign kept_inc = (s4_keep_reg && (kept_reg < KEEP_CAP)) ? kept_reg + 1'b1 : kept_reg;

    always_comb begin
        kept_next = kept_reg;
        if (v4_reg && rdy_out) begin
            kept_next = s4_pt_reg.last ? '0 : kept_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_reg <= '0;
        end else begin
            kept_reg <= kept_next;
        end
    end

    // ---------------- output register ----------------
    logic [pccf_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                          m_has_reg, m_last_reg;

    always_comb begin
        m_data_next = '0;
        if (s4_keep_reg) begin
            m_data_next[19:0]    = s4_pt_reg.x;
            m_data_next[39:20]   = s4_pt_reg.y;
            m_data_next[59:40]   = s4_pt_reg.z;
            m_data_next[67:60]   = s4_pt_reg.reflectivity;
            m_data_next[75:68]   = s4_pt_reg.tag;
            m_data_next[83:76]   = s4_pt_reg.line;
            m_data_next[115:84]  = s4_pt_reg.offset_time;
        end
        if (s4_pt_reg.last) begin
            m_data_next[135:116] = kept_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rdy_out) begin
            m_valid_reg <= v4_reg && (s4_keep_reg || s4_pt_reg.last);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_out) begin
            m_data_reg <= m_data_next;
            m_has_reg  <= s4_keep_reg;
            m_last_reg <= s4_pt_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_has_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
